FILE: design/tah_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_pkg
// shared widths, angle table and helpers for the tilt and heading pipeline
// ----------------------------------------------------------------------------
package tah_pkg;

  // operand width: 16-bit sample << 12, plus cordic growth and sign
  localparam int DW = 32;
  // angle accumulator width in 1/16384 degree units
  localparam int ZW = 24;
  localparam int MAX_STEPS = 24;
  localparam int SCALE_SH = 12;

  localparam logic [31:0] INV_GAIN = 32'd1304065748;
  localparam logic [31:0] GAIN_CORR = 32'd869377165;

  localparam logic signed [ZW-1:0] QUARTER = 24'sd1474560;
  localparam logic signed [15:0] PITCH_LIM = 16'sd5760;
  localparam logic signed [15:0] HALF_TURN = 16'sd11520;
  localparam logic signed [15:0] FULL_TURN = 16'sd23040;

  typedef logic signed [DW-1:0] opnd_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    opnd_t x;
    opnd_t y;
    ang_t  z;
    logic  zero;
  } cvec_t;

  // atan(2^-i) in 1/16384 degree
  function automatic ang_t atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 24'sd737280;
      5'd1:  atan_lut = 24'sd435242;
      5'd2:  atan_lut = 24'sd229970;
      5'd3:  atan_lut = 24'sd116736;
      5'd4:  atan_lut = 24'sd58595;
      5'd5:  atan_lut = 24'sd29326;
      5'd6:  atan_lut = 24'sd14667;
      5'd7:  atan_lut = 24'sd7334;
      5'd8:  atan_lut = 24'sd3667;
      5'd9:  atan_lut = 24'sd1833;
      5'd10: atan_lut = 24'sd917;
      5'd11: atan_lut = 24'sd458;
      5'd12: atan_lut = 24'sd229;
      5'd13: atan_lut = 24'sd115;
      5'd14: atan_lut = 24'sd57;
      5'd15: atan_lut = 24'sd29;
      5'd16: atan_lut = 24'sd14;
      5'd17: atan_lut = 24'sd7;
      5'd18: atan_lut = 24'sd4;
      5'd19: atan_lut = 24'sd2;
      5'd20: atan_lut = 24'sd1;
      default: atan_lut = '0;
    endcase
  endfunction

  // quadrant pre-rotation into the right half plane
  function automatic cvec_t pre_rot(input opnd_t x, input opnd_t y);
    cvec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y;
        v.y = -x;
        v.z = QUARTER;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -QUARTER;
      end
    end else begin
      v.x = x;
      v.y = y;
      v.z = '0;
    end
    return v;
  endfunction

  // final angle in 1/64 degree, zero vector gives 0
  function automatic logic signed [15:0] ang_out(input cvec_t v);
    ang_t r;
    r = (v.z + ang_t'(128)) >>> 8;
    if (v.zero) begin
      return '0;
    end
    return 16'(r);
  endfunction

endpackage

FILE: design/tah_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_cordic
// one registered vectoring micro-rotation with side-band pass-through
// ----------------------------------------------------------------------------
module tah_cordic #(
  parameter int STEP = 0,
  parameter int SBW = 1
) (
  input  logic             clk,
  input  logic             en,
  input  tah_pkg::cvec_t   v_in,
  input  logic [SBW-1:0]   sb_in,
  output tah_pkg::cvec_t   v_out,
  output logic [SBW-1:0]   sb_out
);
  import tah_pkg::*;

  cvec_t v_nxt, v_r;
  logic [SBW-1:0] sb_r;

  // rotate toward the x axis
  always_comb begin
    v_nxt = v_in;
    if (v_in.y >= 0) begin
      v_nxt.x = v_in.x + (v_in.y >>> STEP);
      v_nxt.y = v_in.y - (v_in.x >>> STEP);
      v_nxt.z = v_in.z + atan_lut(5'(STEP));
    end else begin
      v_nxt.x = v_in.x - (v_in.y >>> STEP);
      v_nxt.y = v_in.y + (v_in.x >>> STEP);
      v_nxt.z = v_in.z - atan_lut(5'(STEP));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= v_nxt;
      sb_r <= sb_in;
    end
  end

  assign v_out  = v_r;
  assign sb_out = sb_r;
endmodule

FILE: design/tah_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_chain
// unrolled cordic pipeline, one stage per micro-rotation
// ----------------------------------------------------------------------------
module tah_chain #(
  parameter int STEPS = 16,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           en,
  input  tah_pkg::cvec_t v_in,
  input  logic [SBW-1:0] sb_in,
  output tah_pkg::cvec_t v_out,
  output logic [SBW-1:0] sb_out
);
  import tah_pkg::*;

  cvec_t          v_w  [STEPS+1];
  logic [SBW-1:0] sb_w [STEPS+1];

  assign v_w[0]  = v_in;
  assign sb_w[0] = sb_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    tah_cordic #(.STEP(i), .SBW(SBW)) u_st (
      .clk(clk), .en(en), .v_in(v_w[i]), .sb_in(sb_w[i]),
      .v_out(v_w[i+1]), .sb_out(sb_w[i+1])
    );
  end

  assign v_out  = v_w[STEPS];
  assign sb_out = sb_w[STEPS];
endmodule

FILE: design/tilt_and_heading_from_imu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_and_heading_from_imu
// roll, pitch and heading from one accelerometer and magnetometer sample
// ----------------------------------------------------------------------------
// Input beat: acc_x/y/z and field_x/y raw signed samples. Output beat:
// pitch_angle, roll_angle, heading_angle in 1/64 degree.
// Two cordic chains run back to back: the first on (acc_z, acc_y) and
// (field_x, field_y) side by side gives roll, heading and the vector length;
// the length goes through a gain multiply stage, then the second chain on
// (length, -acc_x) gives pitch.
// Registers in order: input reg, chain, gain, chain, output reg.
// Throughput: one beat per cycle; the whole pipe is a single enabled
// shift, so it advances whenever the output register is empty or taken.
// A stall on out_ready freezes every stage; nothing is lost or repeated.
// Reset clears the valid bits only; data registers need no reset.
// ----------------------------------------------------------------------------
module tilt_and_heading_from_imu #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_acc_x,
  input  logic signed [15:0] in_acc_y,
  input  logic signed [15:0] in_acc_z,
  input  logic signed [15:0] in_field_x,
  input  logic signed [15:0] in_field_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_pitch_angle,
  output logic signed [14:0] out_roll_angle,
  output logic        [14:0] out_heading_angle
);
  import tah_pkg::*;

  localparam int NS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int LAT = 2 * NS + 3;
  localparam logic [31:0] GAIN = INV_GAIN + (GAIN_CORR >> (2 * NS));
  localparam int SB2 = 32;

  logic en;
  logic [LAT-1:0] vld_r, vld_nxt;

  // whole pipe advances when the last slot is free or taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end
  assign out_valid = vld_r[LAT-1];

  // input stage: scale and pre-rotate
  cvec_t roll_r, head_r;
  logic signed [15:0] ax_r;
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r <= pre_rot(opnd_t'(in_acc_z) <<< SCALE_SH, opnd_t'(in_acc_y) <<< SCALE_SH);
      head_r <= pre_rot(opnd_t'(in_field_x) <<< SCALE_SH,
                        opnd_t'(in_field_y) <<< SCALE_SH);
      ax_r   <= in_acc_x;
    end
  end

  // first chain: roll with the upper half of acc_x riding along
  cvec_t roll_c;
  logic [7:0] sb1_o, sbh_o;
  cvec_t h_chain_in, h_chain_out;
  tah_chain #(.STEPS(NS), .SBW(8)) u_ch1 (
    .clk(clk), .en(en), .v_in(roll_r), .sb_in(ax_r[15:8]),
    .v_out(roll_c), .sb_out(sb1_o)
  );
  // heading chain in parallel, lower half of acc_x riding along
  assign h_chain_in = head_r;
  tah_chain #(.STEPS(NS), .SBW(8)) u_chh (
    .clk(clk), .en(en), .v_in(h_chain_in), .sb_in(ax_r[7:0]),
    .v_out(h_chain_out), .sb_out(sbh_o)
  );

  // gain stage: length times inverse gain, and stash roll and heading angles
  logic [63:0] prod;
  logic [31:0] mag_u;
  logic [31:0] mag_r;
  logic signed [15:0] ax1, roll_a, head_a;
  logic signed [15:0] roll1_r, head1_r, ax1_r;
  assign ax1 = {sb1_o, sbh_o};
  assign mag_u = (roll_c.zero || roll_c.x < 0) ? '0 : 32'(roll_c.x);
  assign prod = 64'(mag_u) * 64'(GAIN) + (64'd1 << 30);

  always_comb begin
    roll_a = ang_out(roll_c);
    if (roll_a > HALF_TURN) roll_a = HALF_TURN;
    if (roll_a < -HALF_TURN) roll_a = -HALF_TURN;
    head_a = ang_out(h_chain_out);
    if (head_a > HALF_TURN) head_a = HALF_TURN;
    if (head_a < -HALF_TURN) head_a = -HALF_TURN;
    if (head_a < 0) head_a = head_a + FULL_TURN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= prod[62:31];
      roll1_r <= roll_a;
      head1_r <= head_a;
      ax1_r   <= ax1;
    end
  end

  // second chain: pitch
  cvec_t pit_in, pit_c;
  logic [SB2-1:0] sb2_o;
  assign pit_in = pre_rot(opnd_t'(mag_r), -(opnd_t'(ax1_r) <<< SCALE_SH));
  tah_chain #(.STEPS(NS), .SBW(SB2)) u_ch2 (
    .clk(clk), .en(en), .v_in(pit_in), .sb_in({roll1_r, head1_r}),
    .v_out(pit_c), .sb_out(sb2_o)
  );

  // output register
  logic signed [15:0] pit_a;
  logic signed [13:0] pitch_r;
  logic signed [14:0] roll_r2;
  logic [14:0] head_r2;
  always_comb begin
    pit_a = ang_out(pit_c);
    if (pit_a > PITCH_LIM) pit_a = PITCH_LIM;
    if (pit_a < -PITCH_LIM) pit_a = -PITCH_LIM;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_r <= pit_a[13:0];
      roll_r2 <= sb2_o[30:16];
      head_r2 <= sb2_o[14:0];
    end
  end

  assign out_pitch_angle   = pitch_r;
  assign out_roll_angle    = roll_r2;
  assign out_heading_angle = head_r2;
endmodule

FILE: dv/tb_tilt_and_heading_from_imu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_and_heading_from_imu
// self-checking bench for the tilt and heading pipeline
// ----------------------------------------------------------------------------
// A queue of samples feeds a burst driver on the input channel. A
// bit-accurate cordic predictor fills a queue of expected angles for every
// accepted beat, and the monitor compares each output beat against it while
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_tilt_and_heading_from_imu;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 3;
  localparam int N_RANDOM = 1200;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
  } sample_t;

  typedef struct packed {
    logic signed [13:0] pitch;
    logic signed [14:0] roll;
    logic [14:0]        heading;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_acc_x = '0;
  logic signed [15:0] in_acc_y = '0;
  logic signed [15:0] in_acc_z = '0;
  logic signed [15:0] in_field_x = '0;
  logic signed [15:0] in_field_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [13:0] out_pitch_angle;
  logic signed [14:0] out_roll_angle;
  logic [14:0] out_heading_angle;

  sample_t pending_samples[$];
  angles_t expected_angles[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  logic in_ready_seen = 1'b0;

  tilt_and_heading_from_imu #(.CORDIC_STEPS(STEPS)) dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  // vectoring cordic: angle in 1/64 degree, magnitude returned by ref
  function automatic longint cordic_angle(longint x, longint y, ref longint mag);
    longint z, t, dx, dy;
    int n;
    longint atan_q[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667,
                          7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
                          4, 2, 1, 0, 0, 0};
    z = 0;
    n = (STEPS > 24) ? 24 : STEPS;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * 16384;
      end else begin
        x = -y;
        y = t;
        z = -90 * 16384;
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += atan_q[i];
      end else begin
        x -= dx;
        y += dy;
        z -= atan_q[i];
      end
    end
    mag = x;
    return floor_sh(z + 128, 8);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic angles_t predict_angles(sample_t s);
    longint ax, ay, az, mx, my, raw_mag, spare, roll, pitch, head, mag;
    longint unsigned gain, prod;
    angles_t r;
    ax = longint'(s.ax) * 4096;
    ay = longint'(s.ay) * 4096;
    az = longint'(s.az) * 4096;
    mx = longint'(s.fx) * 4096;
    my = longint'(s.fy) * 4096;
    roll = clip(cordic_angle(az, ay, raw_mag), -11520, 11520);
    if (raw_mag < 0) raw_mag = 0;
    gain = 64'd1304065748 + (64'd869377165 >> (2 * ((STEPS > 24) ? 24 : STEPS)));
    prod = longint'(raw_mag) * gain + (64'd1 << 30);
    mag = longint'(prod >> 31);
    pitch = clip(cordic_angle(mag, -ax, spare), -5760, 5760);
    head = clip(cordic_angle(mx, my, spare), -11520, 11520);
    if (head < 0) head += 23040;
    if (head >= 23040) head -= 23040;
    r.pitch = pitch[13:0];
    r.roll = roll[14:0];
    r.heading = head[14:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // directed corners, then random samples
  initial begin
    sample_t s;
    logic signed [15:0] corner[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
    pending_samples.push_back('0);
    for (int i = 0; i < 5; i++) begin
      s.ax = corner[i]; s.ay = corner[(i + 1) % 5]; s.az = corner[(i + 2) % 5];
      s.fx = corner[(i + 3) % 5]; s.fy = corner[(i + 4) % 5];
      pending_samples.push_back(s);
    end
    // negative x axis with zero y on both atan2 inputs
    pending_samples.push_back('{16'sh7fff, 16'sh0000, 16'sh8000, 16'sh8000, 16'sh0000});
    pending_samples.push_back('{16'sh8000, 16'shffff, 16'sh8000, 16'sh8000, 16'shffff});
    pending_samples.push_back('{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000});
    pending_samples.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    pending_samples.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
    pending_samples.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000});
    for (int i = 0; i < N_RANDOM; i++) begin
      s.ax = rand_field(); s.ay = rand_field(); s.az = rand_field();
      s.fx = rand_field(); s.fy = rand_field();
      pending_samples.push_back(s);
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // driver: bursts with random gaps, payload changes only after acceptance
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_ready_seen)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_acc_x <= pending_samples[0].ax;
        in_acc_y <= pending_samples[0].ay;
        in_acc_z <= pending_samples[0].az;
        in_field_x <= pending_samples[0].fx;
        in_field_y <= pending_samples[0].fy;
        void'(pending_samples.pop_front());
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // acceptance seen at the rising edge, predict on it
  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (rst_n && in_valid && in_ready) begin
      in_ready_seen <= 1'b1;
      expected_angles.push_back(predict_angles(
        '{in_acc_x, in_acc_y, in_acc_z, in_field_x, in_field_y}));
    end
  end

  // receiver stall pattern: long open stretches, then choppy ones
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 100) out_ready <= 1'b1;
    else if (stall_phase < 200) out_ready <= ($urandom_range(0, 2) != 0);
    else out_ready <= (((stall_phase / 7) % 2) == 0) && ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk) begin
    angles_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat");
      end else begin
        exp_a = expected_angles.pop_front();
        if (out_pitch_angle !== exp_a.pitch || out_roll_angle !== exp_a.roll ||
            out_heading_angle !== exp_a.heading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pitch %0d/%0d roll %0d/%0d heading %0d/%0d (exp/act)",
                     exp_a.pitch, out_pitch_angle, exp_a.roll, out_roll_angle,
                     exp_a.heading, out_heading_angle);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (rst_n);
    while (pending_samples.size() > 0 || in_valid || expected_angles.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
